// ----- src/tza_pkg.sv -----
package tza_pkg;

    localparam int unsigned DATA_W  = 48;
    localparam int unsigned USER_W  = 2;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] REG_OFFSET_HOURS = 1'd0;
    localparam logic [CIDX_W-1:0] REG_TWELVE_HOUR  = 1'd1;

    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [4:0] HALF_DAY      = 5'd12;
    localparam logic [3:0] MONTH_JAN     = 4'd1;
    localparam logic [3:0] MONTH_DEC     = 4'd12;
    localparam logic [4:0] DAYS_LONG     = 5'd31;

    // The first field sits in the lowest bits, so it is the last member.
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } t_clock;

    localparam int unsigned CLOCK_W = $bits(t_clock);

    typedef struct packed {
        logic bad_month;
        logic is_pm;
    } t_flags;

    typedef struct packed {
        logic fwd;
        logic back;
    } t_step;

    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        len = 5'd31;
        case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic month_ok(input logic [3:0] m);
        return (m >= MONTH_JAN) && (m <= MONTH_DEC);
    endfunction

endpackage

// ----- src/tza_hour.sv -----
module tza_hour (
    input  logic              i_twelve,
    input  logic signed [4:0] i_offset,
    input  logic [4:0]        i_hour,
    output logic [4:0]        o_hour,
    output logic              o_is_pm,
    output tza_pkg::t_step    o_step
);

    logic signed [6:0] sum;
    logic [4:0]        hour24;

    always_comb begin
        sum = $signed({2'b00, i_hour}) + $signed({{2{i_offset[4]}}, i_offset});
        o_step = '0;
        if (sum >= $signed({2'b00, tza_pkg::HOURS_PER_DAY})) begin
            hour24 = 5'(sum - $signed({2'b00, tza_pkg::HOURS_PER_DAY}));
            o_step.fwd = 1'b1;
        end else if (sum[6]) begin
            hour24 = 5'(sum + $signed({2'b00, tza_pkg::HOURS_PER_DAY}));
            o_step.back = 1'b1;
        end else begin
            hour24 = 5'(sum);
        end

        o_is_pm = 1'b0;
        o_hour  = hour24;
        if (i_twelve && (hour24 >= tza_pkg::HALF_DAY)) begin
            o_is_pm = 1'b1;
            o_hour  = hour24 - tza_pkg::HALF_DAY;
        end
    end

endmodule

// ----- src/tza_date.sv -----
module tza_date (
    input  tza_pkg::t_step i_step,
    input  logic [15:0]    i_year,
    input  logic [3:0]     i_month,
    input  logic [4:0]     i_day,
    output logic [15:0]    o_year,
    output logic [3:0]     o_month,
    output logic [4:0]     o_day,
    output logic           o_bad_month
);

    logic [3:0] prev_month;

    always_comb begin
        o_year      = i_year;
        o_month     = i_month;
        o_day       = i_day;
        o_bad_month = 1'b0;
        prev_month  = i_month - 4'd1;

        if ((i_step.fwd || i_step.back) && !tza_pkg::month_ok(i_month)) begin
            o_bad_month = 1'b1;
        end else if (i_step.fwd) begin
            if (i_day >= tza_pkg::month_length(i_month)) begin
                o_day = 5'd1;
                if (i_month == tza_pkg::MONTH_DEC) begin
                    o_month = tza_pkg::MONTH_JAN;
                    o_year  = i_year + 16'd1;
                end else begin
                    o_month = i_month + 4'd1;
                end
            end else begin
                o_day = i_day + 5'd1;
            end
        end else if (i_step.back) begin
            if (i_day <= 5'd1) begin
                if (i_month == tza_pkg::MONTH_JAN) begin
                    o_month = tza_pkg::MONTH_DEC;
                    o_year  = i_year - 16'd1;
                    o_day   = tza_pkg::DAYS_LONG;
                end else begin
                    o_month = prev_month;
                    o_day   = tza_pkg::month_length(prev_month);
                end
            end else begin
                o_day = i_day - 5'd1;
            end
        end
    end

endmodule

// ----- src/timezone_date_adjust_core.sv -----
// A request accepted into the input register passes through the result register to the result port.
// Throughput: one request per cycle; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Reset (synchronous, active low) empties both stages, sets the offset to zero
// and selects 24-hour mode.
module timezone_date_adjust_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // in_year, in_month, in_day, in_hour, in_minute, in_second, zero fill
    input  logic [tza_pkg::DATA_W-1:0]    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // out_year, out_month, out_day, out_hour, out_minute, out_second, zero fill
    output logic [tza_pkg::DATA_W-1:0]    o_m_axis_tdata,
    // is_pm, bad_month
    output logic [tza_pkg::USER_W-1:0]    o_m_axis_tuser,
    input  logic                          i_cfg_wr_en,
    input  logic [tza_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [tza_pkg::CFG_W-1:0]     i_cfg_data
);

    logic signed [4:0] r_offset;
    logic              r_twelve;
    logic              r_in_valid;
    tza_pkg::t_clock   r_in;
    logic              r_out_valid;
    tza_pkg::t_clock   r_out;
    tza_pkg::t_flags   r_flags;

    tza_pkg::t_clock   n_out;
    tza_pkg::t_flags   n_flags;
    tza_pkg::t_step    step;
    logic              out_ready;
    logic              in_ready;

    assign out_ready = !r_out_valid || i_m_axis_tready;
    assign in_ready  = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_twelve <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tza_pkg::REG_OFFSET_HOURS: r_offset <= $signed(i_cfg_data);
                tza_pkg::REG_TWELVE_HOUR:  r_twelve <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in <= tza_pkg::t_clock'(i_s_axis_tdata[tza_pkg::CLOCK_W-1:0]);
        end
        if (out_ready && r_in_valid) begin
            r_out   <= n_out;
            r_flags <= n_flags;
        end
    end

    tza_hour u_hour (
        .i_twelve (r_twelve),
        .i_offset (r_offset),
        .i_hour   (r_in.hour),
        .o_hour   (n_out.hour),
        .o_is_pm  (n_flags.is_pm),
        .o_step   (step)
    );

    tza_date u_date (
        .i_step      (step),
        .i_year      (r_in.year),
        .i_month     (r_in.month),
        .i_day       (r_in.day),
        .o_year      (n_out.year),
        .o_month     (n_out.month),
        .o_day       (n_out.day),
        .o_bad_month (n_flags.bad_month)
    );

    assign n_out.minute = r_in.minute;
    assign n_out.second = r_in.second;

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tza_pkg::DATA_W - tza_pkg::CLOCK_W){1'b0}}, r_out};
    assign o_m_axis_tuser  = r_flags;

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.hour < tza_pkg::HOURS_PER_DAY))
        else $error("adjusted hour out of range");

    a_twelve_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_twelve) |-> (r_out.hour < tza_pkg::HALF_DAY))
        else $error("twelve-hour result not below twelve");

    a_pm_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.is_pm) |-> r_twelve)
        else $error("PM flag outside twelve-hour mode");

    a_bad_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.bad_month) |->
            ((r_out.month == 4'd0) || (r_out.month > tza_pkg::MONTH_DEC)))
        else $error("bad month flagged on a valid month");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |=> (r_in_valid && $stable(r_in)))
        else $error("input stage lost a request while stalled");

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD   = 80;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES      = 7;

    typedef struct packed {
        tza_pkg::t_flags flags;
        tza_pkg::t_clock clock;
    } t_adjusted;

    // Tracks the zone settings and the adjusted readings still owed by the block.
    class adjusted_time_board;
        t_adjusted         pending_times[$];
        logic signed [4:0] offset_hours;
        logic              twelve_hour;
        int                errors;

        function new();
            offset_hours = '0;
            twelve_hour  = 1'b0;
            errors       = 0;
        endfunction

        function void set_register(logic [tza_pkg::CIDX_W-1:0] idx,
                                   logic [tza_pkg::CFG_W-1:0] val);
            if (idx == tza_pkg::REG_OFFSET_HOURS) begin
                offset_hours = val[4:0];
            end else if (idx == tza_pkg::REG_TWELVE_HOUR) begin
                twelve_hour = val[0];
            end
        endfunction

        function int unsigned month_days(logic [3:0] m);
            case (m)
                4'd2: return 28;
                4'd4, 4'd6, 4'd9, 4'd11: return 30;
                default: return 31;
            endcase
        endfunction

        function t_adjusted adjust_reading(tza_pkg::t_clock rd);
            t_adjusted r;
            int        hsum;
            int        dir;
            r       = '0;
            r.clock = rd;
            hsum    = int'(rd.hour) + int'(offset_hours);
            dir     = 0;
            if (hsum >= int'(tza_pkg::HOURS_PER_DAY)) begin
                hsum -= int'(tza_pkg::HOURS_PER_DAY);
                dir = 1;
            end else if (hsum < 0) begin
                hsum += int'(tza_pkg::HOURS_PER_DAY);
                dir = -1;
            end
            if (dir != 0 && (rd.month < tza_pkg::MONTH_JAN ||
                             rd.month > tza_pkg::MONTH_DEC)) begin
                r.flags.bad_month = 1'b1;
            end else if (dir > 0) begin
                if (rd.day >= month_days(rd.month)) begin
                    r.clock.day = 5'd1;
                    if (rd.month == tza_pkg::MONTH_DEC) begin
                        r.clock.month = tza_pkg::MONTH_JAN;
                        r.clock.year  = rd.year + 16'd1;
                    end else begin
                        r.clock.month = rd.month + 4'd1;
                    end
                end else begin
                    r.clock.day = rd.day + 5'd1;
                end
            end else if (dir < 0) begin
                if (rd.day <= 5'd1) begin
                    if (rd.month == tza_pkg::MONTH_JAN) begin
                        r.clock.month = tza_pkg::MONTH_DEC;
                        r.clock.year  = rd.year - 16'd1;
                        r.clock.day   = tza_pkg::DAYS_LONG;
                    end else begin
                        r.clock.month = rd.month - 4'd1;
                        r.clock.day   = 5'(month_days(rd.month - 4'd1));
                    end
                end else begin
                    r.clock.day = rd.day - 5'd1;
                end
            end
            if (twelve_hour) begin
                r.flags.is_pm = (hsum >= int'(tza_pkg::HALF_DAY));
                hsum = hsum % int'(tza_pkg::HALF_DAY);
            end
            r.clock.hour = 5'(hsum);
            return r;
        endfunction

        function void note_reading(tza_pkg::t_clock rd);
            pending_times.push_back(adjust_reading(rd));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_adjusted(tza_pkg::t_clock got, tza_pkg::t_flags got_flags);
            t_adjusted want;
            if (pending_times.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h/%b",
                         $time, got, got_flags);
                return;
            end
            want = pending_times.pop_front();
            compare_field("out_year",   want.clock.year,        got.year);
            compare_field("out_month",  want.clock.month,       got.month);
            compare_field("out_day",    want.clock.day,         got.day);
            compare_field("out_hour",   want.clock.hour,        got.hour);
            compare_field("out_minute", want.clock.minute,      got.minute);
            compare_field("out_second", want.clock.second,      got.second);
            compare_field("is_pm",      want.flags.is_pm,       got_flags.is_pm);
            compare_field("bad_month",  want.flags.bad_month,   got_flags.bad_month);
        endfunction
    endclass

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [tza_pkg::DATA_W-1:0]        i_s_axis_tdata  = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [tza_pkg::DATA_W-1:0]        o_m_axis_tdata;
    logic [tza_pkg::USER_W-1:0]        o_m_axis_tuser;
    logic                              i_cfg_wr_en     = 1'b0;
    logic [tza_pkg::CIDX_W-1:0]        i_cfg_index     = '0;
    logic [tza_pkg::CFG_W-1:0]         i_cfg_data      = '0;

    adjusted_time_board board = new();
    logic calm;
    logic hold_pending;

    timezone_date_adjust_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic tza_pkg::t_clock reading(int y, int m, int d, int h, int mi, int s);
        tza_pkg::t_clock rd;
        rd.year   = 16'(y);
        rd.month  = 4'(m);
        rd.day    = 5'(d);
        rd.hour   = 5'(h);
        rd.minute = 6'(mi);
        rd.second = 6'(s);
        return rd;
    endfunction

    function automatic tza_pkg::t_clock random_reading();
        tza_pkg::t_clock rd;
        logic [63:0]     raw;
        if ($urandom_range(0, 4) == 0) begin
            raw = {$urandom, $urandom};
            rd  = raw[tza_pkg::CLOCK_W-1:0];
        end else begin
            if ($urandom_range(0, 7) == 0) begin
                rd.year = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            end else begin
                rd.year = 16'($urandom);
            end
            rd.month = 4'($urandom_range(1, 12));
            case ($urandom_range(0, 3))
                0: rd.day = 5'd1;
                1: rd.day = 5'($urandom_range(28, 31));
                default: rd.day = 5'($urandom_range(1, 31));
            endcase
            case ($urandom_range(0, 2))
                0: rd.hour = 5'($urandom_range(0, 3));
                1: rd.hour = 5'($urandom_range(20, 23));
                default: rd.hour = 5'($urandom_range(0, 23));
            endcase
            rd.minute = 6'($urandom_range(0, 59));
            rd.second = 6'($urandom_range(0, 59));
        end
        return rd;
    endfunction

    task automatic send_reading(tza_pkg::t_clock rd);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(tza_pkg::DATA_W-tza_pkg::CLOCK_W){1'b0}}, rd};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        board.note_reading(rd);
    endtask

    // Waits until the block has returned every request, then loads both zone registers.
    task automatic load_zone(logic [4:0] offset, logic twelve);
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_times.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= tza_pkg::REG_OFFSET_HOURS;
        i_cfg_data  <= tza_pkg::CFG_W'(offset);
        @(posedge i_clk);
        board.set_register(tza_pkg::REG_OFFSET_HOURS, tza_pkg::CFG_W'(offset));
        i_cfg_index <= tza_pkg::REG_TWELVE_HOUR;
        i_cfg_data  <= tza_pkg::CFG_W'(twelve);
        @(posedge i_clk);
        board.set_register(tza_pkg::REG_TWELVE_HOUR, tza_pkg::CFG_W'(twelve));
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_adjusted(o_m_axis_tdata[tza_pkg::CLOCK_W-1:0], o_m_axis_tuser);
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("FAIL timezone_date_adjust_core");
                $finish;
            end
        end
    end

    initial begin
        logic [4:0] offsets [PHASES];
        logic       twelves [PHASES];
        calm         = 1'b0;
        hold_pending = 1'b0;
        offsets = '{5'd0, 5'd14, -5'sd12, 5'd15, -5'sd16, 5'($urandom_range(0, 31)), 5'd5};
        twelves = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No offset: only an out-of-range hour can step the date.
        send_reading(reading(0, 0, 0, 0, 0, 0));
        send_reading(reading(2024, 6, 15, 23, 59, 59));
        send_reading(reading(2024, 3, 10, 24, 1, 2));
        send_reading(reading(16'hffff, 12, 31, 31, 63, 63));
        send_reading(reading(2000, 0, 5, 25, 30, 30));
        send_reading(reading(16'hffff, 15, 31, 31, 63, 63));

        // Forward steps across month and year ends, twelve-hour output.
        load_zone(5'd14, 1'b1);
        send_reading(reading(1999, 1, 31, 23, 10, 20));
        send_reading(reading(1999, 2, 28, 12, 0, 0));
        send_reading(reading(1999, 4, 30, 10, 0, 0));
        send_reading(reading(1999, 4, 29, 15, 0, 0));
        send_reading(reading(1999, 7, 3, 9, 0, 0));
        send_reading(reading(1999, 7, 3, 0, 0, 0));
        send_reading(reading(1999, 13, 3, 10, 0, 0));
        send_reading(reading(16'hffff, 12, 31, 11, 0, 0));

        // Backward steps across month and year ends.
        load_zone(-5'sd12, 1'b1);
        send_reading(reading(0, 1, 1, 0, 0, 0));
        send_reading(reading(2010, 3, 1, 5, 0, 0));
        send_reading(reading(2010, 5, 1, 11, 0, 0));
        send_reading(reading(2010, 8, 0, 2, 0, 0));
        send_reading(reading(2010, 6, 15, 3, 0, 0));
        send_reading(reading(2010, 6, 15, 12, 0, 0));
        send_reading(reading(2010, 0, 15, 3, 0, 0));

        for (int p = 0; p < PHASES; p++) begin
            load_zone(offsets[p], twelves[p]);
            if (p == 0) begin
                hold_pending = 1'b1;
            end
            if (p == PHASES - 1) begin
                calm = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_reading(random_reading());
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (board.pending_times.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS timezone_date_adjust_core");
        end else begin
            $display("FAIL timezone_date_adjust_core");
        end
        $finish;
    end
endmodule
